### src/itoa_pkg.sv
`timescale 1ns / 1ps

package itoa_pkg;

    // Default width of the signed input value.
    localparam int VALUE_WIDTH_DEF = 32;

    // Width of one ASCII code on the output.
    localparam int CHAR_W = 6;

    // Character codes.
    localparam logic [CHAR_W-1:0] ASCII_ZERO  = 6'd48;
    localparam logic [CHAR_W-1:0] ASCII_MINUS = 6'd45;

    // Number of decimal digits needed for a magnitude of up to 2^(w-1).
    // 1233/4096 approximates log10(2) closely enough for w up to 64.
    function automatic int digit_count(input int w);
        return (((w - 1) * 1233) >> 12) + 1;
    endfunction

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_SKIP,
        ST_SIGN,
        ST_DIGITS
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic conv_step;
        logic shift_digit;
        logic emit_sign;
        logic emit_digit;
    } itoa_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic top_zero;
        logic digit_one;
        logic bit_one;
        logic neg;
        logic out_free;
    } itoa_sts_t;

endpackage

### src/itoa_ctrl.sv
`timescale 1ns / 1ps

module itoa_ctrl
    import itoa_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      s_tvalid,
    output logic      s_tready,
    input  itoa_sts_t sts,
    output itoa_cmd_t cmd
);

    state_t state_reg;
    state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ST_CONV;
                end
            end
            ST_CONV:
            begin
                if (sts.bit_one)
                begin
                    state_next = ST_SKIP;
                end
            end
            ST_SKIP:
            begin
                if (!(sts.top_zero && !sts.digit_one))
                begin
                    state_next = sts.neg ? ST_SIGN : ST_DIGITS;
                end
            end
            ST_SIGN:
            begin
                if (sts.out_free)
                begin
                    state_next = ST_DIGITS;
                end
            end
            ST_DIGITS:
            begin
                if (sts.out_free && sts.digit_one)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs: the input side is open only between conversions.
    always_comb
    begin
        s_tready = 1'b0;
        cmd      = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            ST_CONV:
            begin
                cmd.conv_step = 1'b1;
            end
            ST_SKIP:
            begin
                cmd.shift_digit = sts.top_zero && !sts.digit_one;
            end
            ST_SIGN:
            begin
                cmd.emit_sign = sts.out_free;
            end
            ST_DIGITS:
            begin
                cmd.emit_digit = sts.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

`ifndef ASSERT_OFF
    // Characters are loaded only when the output register can take them.
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit_sign || cmd.emit_digit) |-> sts.out_free)
        else $error("character loaded while output register is busy");

    // At most one datapath command per cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load, cmd.conv_step, cmd.shift_digit, cmd.emit_sign, cmd.emit_digit}))
        else $error("conflicting datapath commands");

    // An accepted item starts the conversion.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> (state_reg == ST_CONV))
        else $error("accepted item did not start conversion");

    // The final digit returns the controller to idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit_digit && sts.digit_one) |=> (state_reg == ST_IDLE))
        else $error("controller did not return to idle after last digit");
`endif

endmodule

### src/itoa_dp.sv
`timescale 1ns / 1ps

module itoa_dp
    import itoa_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [VALUE_WIDTH-1:0] value,
    input  itoa_cmd_t              cmd,
    output itoa_sts_t              sts,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [CHAR_W-1:0]      m_char,
    output logic                   m_last
);

    localparam int NDIG  = digit_count(VALUE_WIDTH);
    localparam int BCD_W = 4 * NDIG;
    localparam int BCW   = $clog2(VALUE_WIDTH + 1);
    localparam int DCW   = $clog2(NDIG + 1);

    logic [VALUE_WIDTH-1:0] mag_reg;
    logic [VALUE_WIDTH-1:0] mag_next;
    logic                   neg_reg;
    logic                   neg_next;
    logic [BCD_W-1:0]       bcd_reg;
    logic [BCD_W-1:0]       bcd_next;
    logic [BCD_W-1:0]       bcd_adj;
    logic [BCW-1:0]         bit_cnt_reg;
    logic [BCW-1:0]         bit_cnt_next;
    logic [DCW-1:0]         dig_cnt_reg;
    logic [DCW-1:0]         dig_cnt_next;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic [CHAR_W-1:0]      out_char_reg;
    logic [CHAR_W-1:0]      out_char_next;
    logic                   out_last_reg;
    logic                   out_last_next;
    logic [3:0]             top_digit;
    logic                   out_free;

    assign top_digit = bcd_reg[BCD_W-1 -: 4];
    assign out_free  = !out_valid_reg || m_tready;

    // Double-dabble correction: every digit of five or more gets three added.
    always_comb
    begin
        for (int i = 0; i < NDIG; i++)
        begin
            if (bcd_reg[4*i +: 4] >= 4'd5)
            begin
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4] + 4'd3;
            end
            else
            begin
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4];
            end
        end
    end

    // Magnitude, BCD and counter updates.
    always_comb
    begin
        mag_next     = mag_reg;
        neg_next     = neg_reg;
        bcd_next     = bcd_reg;
        bit_cnt_next = bit_cnt_reg;
        dig_cnt_next = dig_cnt_reg;
        if (cmd.load)
        begin
            neg_next     = value[VALUE_WIDTH-1];
            mag_next     = value[VALUE_WIDTH-1] ? (~value + VALUE_WIDTH'(1)) : value;
            bcd_next     = '0;
            bit_cnt_next = BCW'(VALUE_WIDTH);
            dig_cnt_next = DCW'(NDIG);
        end
        else if (cmd.conv_step)
        begin
            bcd_next     = {bcd_adj[BCD_W-2:0], mag_reg[VALUE_WIDTH-1]};
            mag_next     = {mag_reg[VALUE_WIDTH-2:0], 1'b0};
            bit_cnt_next = bit_cnt_reg - BCW'(1);
        end
        else if (cmd.shift_digit || cmd.emit_digit)
        begin
            bcd_next     = {bcd_reg[BCD_W-5:0], 4'd0};
            dig_cnt_next = dig_cnt_reg - DCW'(1);
        end
    end

    // Output register: holds a character until the sink takes it.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_char_next  = out_char_reg;
        out_last_next  = out_last_reg;
        if (cmd.emit_sign)
        begin
            out_valid_next = 1'b1;
            out_char_next  = ASCII_MINUS;
            out_last_next  = 1'b0;
        end
        else if (cmd.emit_digit)
        begin
            out_valid_next = 1'b1;
            out_char_next  = ASCII_ZERO + CHAR_W'(top_digit);
            out_last_next  = (dig_cnt_reg == DCW'(1));
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            bit_cnt_reg   <= '0;
            dig_cnt_reg   <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            bit_cnt_reg   <= bit_cnt_next;
            dig_cnt_reg   <= dig_cnt_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        mag_reg      <= mag_next;
        neg_reg      <= neg_next;
        bcd_reg      <= bcd_next;
        out_char_reg <= out_char_next;
        out_last_reg <= out_last_next;
    end

    // Status to the controller.
    always_comb
    begin
        sts.top_zero  = (top_digit == 4'd0);
        sts.digit_one = (dig_cnt_reg == DCW'(1));
        sts.bit_one   = (bit_cnt_reg == BCW'(1));
        sts.neg       = neg_reg;
        sts.out_free  = out_free;
    end

    assign m_tvalid = out_valid_reg;
    assign m_char   = out_char_reg;
    assign m_last   = out_last_reg;

endmodule

### src/signed_int_to_decimal_ascii_core.sv
// The first character is valid after the accepted item has passed the bit-serial
// binary to BCD shifter and the leading zeros in the BCD register have been skipped.
// Each item then steps through every digit position of the BCD register, with a
// minus sign first if negative; a stalled output holds the sign and the digits.
// No new item is taken while a conversion is under way.
// The next item is taken while the last character still waits at the output.
// Reset (rst_n, asynchronous, active low) returns the controller to idle and
// empties the output register.
`timescale 1ns / 1ps

module signed_int_to_decimal_ascii_core
    import itoa_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // value (VALUE_WIDTH bits), zero padded to whole bytes
    input  logic [((VALUE_WIDTH+7)/8)*8-1:0]    s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // char_code (6 bits), two zero bits above
    output logic [7:0]                          m_tdata,
    output logic                                m_tlast
);

    itoa_cmd_t         cmd;
    itoa_sts_t         sts;
    logic [CHAR_W-1:0] char_code;

    // Sequencer.
    itoa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Magnitude, BCD shifter and output register.
    itoa_dp #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .value    (s_tdata[VALUE_WIDTH-1:0]),
        .cmd      (cmd),
        .sts      (sts),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_char   (char_code),
        .m_last   (m_tlast)
    );

    assign m_tdata = {2'b00, char_code};

endmodule

### verif/signed_int_to_decimal_ascii_core_test.sv
`timescale 1ns / 1ps

module signed_int_to_decimal_ascii_core_test;
    import itoa_pkg::*;

    localparam int VW          = VALUE_WIDTH_DEF;
    localparam int DATA_W      = ((VW + 7) / 8) * 8;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int LONG_HOLD   = 600;
    localparam int MAX_REPORTS = 10;

    // One expected character together with the value it came from.
    typedef struct {
        logic [CHAR_W-1:0] code;
        logic              is_last;
        logic [VW-1:0]     value;
    } char_item_t;

    // Keeps the characters still owed by the block and checks each one that arrives.
    class itoa_scoreboard;
        char_item_t  expected_chars[$];
        int unsigned values_taken;
        int unsigned negatives_taken;
        int unsigned chars_checked;
        int unsigned mismatches;

        // Works out the decimal text of an accepted value and queues its characters.
        function void note_value(logic [VW-1:0] value);
            logic [VW-1:0] magnitude;
            logic [3:0]    digits[$];
            char_item_t    ch;
            magnitude = value[VW-1] ? (~value + 1'b1) : value;
            do
            begin
                digits.push_front(4'(magnitude % 10));
                magnitude = magnitude / 10;
            end
            while (magnitude != 0);
            ch.value = value;
            if (value[VW-1])
            begin
                ch.code    = ASCII_MINUS;
                ch.is_last = 1'b0;
                expected_chars.push_back(ch);
                negatives_taken++;
            end
            foreach (digits[i])
            begin
                ch.code    = ASCII_ZERO + digits[i];
                ch.is_last = (i == digits.size() - 1);
                expected_chars.push_back(ch);
            end
            values_taken++;
        endfunction

        // Compares one accepted character with the oldest one still owed.
        function void check_char(logic [7:0] data, logic is_last);
            char_item_t ch;
            chars_checked++;
            if (expected_chars.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("ERROR: unexpected character 0x%02h last=%b", data, is_last);
                return;
            end
            ch = expected_chars.pop_front();
            if (data !== 8'(ch.code) || is_last !== ch.is_last)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("ERROR: value %0d: expected char 0x%02h last=%b, got 0x%02h last=%b",
                             $signed(ch.value), 8'(ch.code), ch.is_last, data, is_last);
            end
        endfunction

        function int unsigned pending();
            return expected_chars.size();
        endfunction
    endclass

    logic              clk;
    logic              rst_n;
    logic              s_tvalid;
    logic              s_tready;
    logic [DATA_W-1:0] s_tdata;
    logic              m_tvalid;
    logic              m_tready;
    logic [7:0]        m_tdata;
    logic              m_tlast;

    itoa_scoreboard sb = new();

    // Idling controls set by the main sequence for the stimulus and the output side.
    bit          tx_idle;
    bit          rx_idle;
    bit          hold_request;
    int unsigned cycle_count;

    signed_int_to_decimal_ascii_core #(
        .VALUE_WIDTH(VW)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Offers one value, optionally after a short idle burst, and waits until it is taken.
    task automatic send_value(input logic [VW-1:0] value);
        if (tx_idle && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= DATA_W'(value);
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.note_value(value);
    endtask

    // Sends a batch of random values, weighted toward boundaries and digit rollovers.
    task automatic send_random_values(input int count);
        logic [VW-1:0] value;
        logic [VW-1:0] power;
        int            exponent;
        repeat (count)
        begin
            case ($urandom_range(0, 5))
                0, 1: value = VW'($urandom);
                2: value = VW'(int'($urandom_range(0, 2000)) - 1000);
                3:
                begin
                    power = 1;
                    exponent = $urandom_range(0, 9);
                    repeat (exponent) power = power * 10;
                    value = power + VW'(int'($urandom_range(0, 2)) - 1);
                    if ($urandom_range(0, 1))
                        value = ~value + 1'b1;
                end
                4:
                begin
                    if ($urandom_range(0, 1))
                        value = {1'b0, {(VW-1){1'b1}}} - VW'($urandom_range(0, 20));
                    else
                        value = {1'b1, {(VW-1){1'b0}}} + VW'($urandom_range(0, 20));
                end
                default:
                begin
                    value = VW'($urandom_range(0, 99999));
                    if ($urandom_range(0, 1))
                        value = ~value + 1'b1;
                end
            endcase
            send_value(value);
        end
    endtask

    // Output side: checks every accepted character and stalls in random bursts or for a long hold on request.
    initial
    begin
        int stall_left;
        stall_left = 0;
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
                sb.check_char(m_tdata, m_tlast);
            if (hold_request)
            begin
                stall_left   = LONG_HOLD;
                hold_request = 1'b0;
            end
            if (stall_left > 0)
            begin
                m_tready <= 1'b0;
                stall_left--;
            end
            else if (rx_idle && $urandom_range(0, 7) == 0)
            begin
                m_tready <= 1'b0;
                stall_left = $urandom_range(0, 16);
            end
            else
                m_tready <= 1'b1;
        end
    end

    // Watchdog on the total run length.
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Test completed with failures");
        $finish;
    end

    // Main sequence: reset, directed values, random phases, then drain and report.
    initial
    begin
        logic [VW-1:0] directed_values[$];
        directed_values = '{
            0, 1, -1, 9, 10, -10, 99, 100, -100, 7, -5,
            32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001, 32'h7FFF_FFFE,
            1000000000, 999999999, -999999999, -1000000000,
            1234567890, -1234567890, 32'hAAAA_AAAA, 32'h5555_5555
        };
        rst_n        <= 1'b0;
        s_tvalid     <= 1'b0;
        s_tdata      <= '0;
        tx_idle      = 1'b1;
        rx_idle      = 1'b1;
        hold_request = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Extremes, zero, sign changes and digit count boundaries.
        foreach (directed_values[i])
            send_value(directed_values[i]);

        // Random values with idling on both sides.
        send_random_values(220);

        // Output held off for a long stretch while values keep coming.
        tx_idle      = 1'b0;
        hold_request = 1'b1;
        send_random_values(20);

        // Final stretch at full rate.
        rx_idle = 1'b0;
        send_random_values(120);
        s_tvalid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (VW + 16) @(posedge clk);

        $display(
            "Converted %0d values (%0d negative, both extremes and zero) into %0d characters.",
            sb.values_taken, sb.negatives_taken, sb.chars_checked);
        $display("Both sides idled at random, and the output was held off once for %0d cycles.",
                 LONG_HOLD);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("Test completed successfully");
        else
        begin
            $display("%0d mismatches, %0d characters still owed", sb.mismatches, sb.pending());
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

### signed_int_to_decimal_ascii_core.f
src/itoa_pkg.sv
src/itoa_ctrl.sv
src/itoa_dp.sv
src/signed_int_to_decimal_ascii_core.sv
verif/signed_int_to_decimal_ascii_core_test.sv
